// ----- rtl/sacm_pkg.sv -----
// ----------------------------------------------------------------------------
// sacm_pkg
// Shared types and constants for the set-associative cache tag model.
// ----------------------------------------------------------------------------
package sacm_pkg;

	localparam int MAX_WAYS = 8;
	localparam int NUM_SETS = 1024;
	localparam int SET_W    = 10;
	localparam int TAG_W    = 58;
	localparam int CNT_W    = 16;
	localparam int TOT_W    = 48;
	localparam int WAY_W    = 3;
	localparam int FILL_W   = 4;
	localparam int ADDR_W   = 4;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCNT_W   = 2;

	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_WB     = 2'd1;
	localparam logic [1:0] REG_WAYS   = 2'd2;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [2:0] {
		POL_LRU  = 3'd0,
		POL_FIFO = 3'd1,
		POL_LIFO = 3'd2,
		POL_MRU  = 3'd3,
		POL_LFU  = 3'd4
	} policy_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_READ,
		BK_UPDATE
	} back_state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             dirty;
		logic [CNT_W-1:0] cnt;
	} entry_t;

	typedef struct packed {
		logic [FILL_W-1:0]          fill;
		entry_t [MAX_WAYS-1:0]      way;
	} row_t;

	// One classified access as it travels from the front to the back.
	typedef struct packed {
		logic              wr;
		logic [SET_W-1:0]  set_index;
		logic [TAG_W-1:0]  tag;
		logic              wb;
		logic [FILL_W-1:0] ways;
		logic              to_front;
		logic              lfu;
		logic              evict_last;
	} job_t;

endpackage

// ----- rtl/sacm_if.sv -----
// ----------------------------------------------------------------------------
// sacm_req_if / sacm_rsp_if
// Valid/ready channels for access requests and their results.
// ----------------------------------------------------------------------------
interface sacm_req_if;
	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [sacm_pkg::SET_W-1:0] set_index;
	logic [sacm_pkg::TAG_W-1:0] tag;

	modport source (output valid, opcode, set_index, tag, input ready);
	modport sink (input valid, opcode, set_index, tag, output ready);
endinterface

interface sacm_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic                       memory_fetch;
	logic                       memory_writeout;
	logic [sacm_pkg::TOT_W-1:0] fetch_total;
	logic [sacm_pkg::TOT_W-1:0] writeout_total;

	modport source (output valid, hit, memory_fetch, memory_writeout, fetch_total,
		writeout_total, input ready);
	modport sink (input valid, hit, memory_fetch, memory_writeout, fetch_total,
		writeout_total, output ready);
endinterface

// ----- rtl/sacm_front.sv -----
// ----------------------------------------------------------------------------
// sacm_front
// Accepts requests and classifies them against the current configuration.
// ----------------------------------------------------------------------------
module sacm_front (
	sacm_req_if.sink                    req,
	input  logic [2:0]                  policy,
	input  logic                        write_back_mode,
	input  logic [sacm_pkg::FILL_W-1:0] ways_in_use,
	input  logic                        clearing,
	input  logic                        q_full,
	output logic                        push,
	output sacm_pkg::job_t              job
);

	assign req.ready = !clearing && !q_full;
	assign push      = req.valid && req.ready;

	always_comb begin
		job            = '0;
		job.wr         = req.opcode;
		job.set_index  = req.set_index;
		job.tag        = req.tag;
		job.wb         = write_back_mode;
		if (ways_in_use == '0) begin
			job.ways = sacm_pkg::FILL_W'(1);
		end else if (ways_in_use > sacm_pkg::FILL_W'(sacm_pkg::MAX_WAYS)) begin
			job.ways = sacm_pkg::FILL_W'(sacm_pkg::MAX_WAYS);
		end else begin
			job.ways = ways_in_use;
		end
		// Codes without a policy of their own replace as FIFO.
		unique case (policy)
			sacm_pkg::POL_LRU: begin
				job.to_front   = 1'b1;
				job.evict_last = 1'b1;
			end
			sacm_pkg::POL_LIFO: begin
				job.evict_last = 1'b1;
			end
			sacm_pkg::POL_MRU: begin
				job.to_front = 1'b1;
			end
			sacm_pkg::POL_LFU: begin
				job.lfu = 1'b1;
			end
			default: begin
				job.to_front = 1'b0;
			end
		endcase
	end

endmodule

// ----- rtl/sacm_queue.sv -----
// ----------------------------------------------------------------------------
// sacm_queue
// Two-entry queue of classified accesses between the front and the back.
// ----------------------------------------------------------------------------
module sacm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sacm_pkg::job_t din,
	input  logic           pop,
	output sacm_pkg::job_t dout,
	output logic           full,
	output logic           empty
);

	sacm_pkg::job_t              slot_q [sacm_pkg::QDEPTH];
	logic [sacm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [sacm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [sacm_pkg::QCNT_W-1:0] count_q;

	assign full  = count_q == sacm_pkg::QCNT_W'(sacm_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/sacm_back.sv -----
// ----------------------------------------------------------------------------
// sacm_back
// Reads a set row, applies hit, fill or eviction, writes the row back and
// registers the result.
// ----------------------------------------------------------------------------
module sacm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sacm_pkg::job_t q_job,
	input  logic           q_empty,
	output logic           pop,
	output logic           clearing,
	sacm_rsp_if.source     rsp
);

	sacm_pkg::back_state_t        state_q, state_d;
	logic [sacm_pkg::SET_W-1:0]   clr_q;
	sacm_pkg::job_t               job_s1;
	sacm_pkg::row_t               row_s1;
	sacm_pkg::row_t               mem [sacm_pkg::NUM_SETS];

	logic                         re, we;
	logic [sacm_pkg::SET_W-1:0]   waddr;
	sacm_pkg::row_t               wdata, new_row;

	logic                         rsp_valid_q, hit_q, fetch_q, wout_q;
	logic [sacm_pkg::TOT_W-1:0]   fetch_tot_q, wout_tot_q;

	logic [sacm_pkg::FILL_W-1:0]  n;
	logic                         found, full, c_fetch, c_wout;
	logic [sacm_pkg::WAY_W-1:0]   hidx, vmin, vic, pos;
	sacm_pkg::entry_t             ent;

	assign clearing = state_q == sacm_pkg::BK_CLEAR;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sacm_pkg::BK_CLEAR: begin
				if (clr_q == sacm_pkg::SET_W'(sacm_pkg::NUM_SETS - 1)) begin
					state_d = sacm_pkg::BK_READ;
				end
			end
			sacm_pkg::BK_READ: begin
				if (pop) begin
					state_d = sacm_pkg::BK_UPDATE;
				end
			end
			sacm_pkg::BK_UPDATE: begin
				state_d = sacm_pkg::BK_READ;
			end
			default: begin
				state_d = sacm_pkg::BK_CLEAR;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		pop   = 1'b0;
		re    = 1'b0;
		we    = 1'b0;
		waddr = job_s1.set_index;
		wdata = new_row;
		unique case (state_q)
			sacm_pkg::BK_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			sacm_pkg::BK_READ: begin
				// The result register is empty by the update if it is free now.
				pop = !q_empty && (!rsp_valid_q || rsp.ready);
				re  = pop;
			end
			sacm_pkg::BK_UPDATE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			row_s1 <= mem[q_job.set_index];
		end
	end

	// Tag compare, victim choice and the updated row.
	always_comb begin
		n = (row_s1.fill > sacm_pkg::FILL_W'(sacm_pkg::MAX_WAYS)) ?
			sacm_pkg::FILL_W'(sacm_pkg::MAX_WAYS) : row_s1.fill;

		found = 1'b0;
		hidx  = '0;
		for (int i = 0; i < sacm_pkg::MAX_WAYS; i++) begin
			if (!found && sacm_pkg::FILL_W'(i) < n &&
					row_s1.way[i].tag == job_s1.tag) begin
				found = 1'b1;
				hidx  = sacm_pkg::WAY_W'(i);
			end
		end

		// First entry holding the least use count.
		vmin = '0;
		for (int i = 1; i < sacm_pkg::MAX_WAYS; i++) begin
			if (sacm_pkg::FILL_W'(i) < n && row_s1.way[i].cnt < row_s1.way[vmin].cnt) begin
				vmin = sacm_pkg::WAY_W'(i);
			end
		end

		full = n >= job_s1.ways;
		if (job_s1.evict_last) begin
			vic = sacm_pkg::WAY_W'(n - 1'b1);
		end else if (job_s1.lfu) begin
			vic = vmin;
		end else begin
			vic = '0;
		end

		new_row = row_s1;
		c_fetch = !found;
		c_wout  = job_s1.wr && !job_s1.wb;
		ent     = '0;
		pos     = '0;

		if (found) begin
			ent       = row_s1.way[hidx];
			ent.dirty = ent.dirty | (job_s1.wr && job_s1.wb);
			if (job_s1.lfu && ent.cnt != '1) begin
				ent.cnt = ent.cnt + 1'b1;
			end
			pos = hidx;
		end else begin
			ent.tag   = job_s1.tag;
			ent.dirty = job_s1.wr;
			ent.cnt   = '0;
			if (full) begin
				pos = vic;
				if (job_s1.wb && row_s1.way[vic].dirty) begin
					c_wout = 1'b1;
				end
			end else begin
				pos          = n[sacm_pkg::WAY_W-1:0];
				new_row.fill = n + 1'b1;
			end
		end

		if (job_s1.to_front) begin
			// Entry goes to slot 0; slots up to the gap shift down by one.
			for (int j = 1; j < sacm_pkg::MAX_WAYS; j++) begin
				if (sacm_pkg::WAY_W'(j) <= pos) begin
					new_row.way[j] = row_s1.way[j-1];
				end
			end
			new_row.way[0] = ent;
		end else if (found || job_s1.lfu || !full) begin
			new_row.way[pos] = ent;
		end else begin
			// Drop the victim, close the gap and append at the back.
			for (int j = 0; j < sacm_pkg::MAX_WAYS - 1; j++) begin
				if (sacm_pkg::WAY_W'(j) >= pos && sacm_pkg::FILL_W'(j + 1) < n) begin
					new_row.way[j] = row_s1.way[j+1];
				end
			end
			new_row.way[sacm_pkg::WAY_W'(n - 1'b1)] = ent;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_s1 <= q_job;
		end
		if (state_q == sacm_pkg::BK_UPDATE) begin
			hit_q   <= found;
			fetch_q <= c_fetch;
			wout_q  <= c_wout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sacm_pkg::BK_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
			fetch_tot_q <= '0;
			wout_tot_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sacm_pkg::BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == sacm_pkg::BK_UPDATE) begin
				rsp_valid_q <= 1'b1;
				if (c_fetch && fetch_tot_q != '1) begin
					fetch_tot_q <= fetch_tot_q + 1'b1;
				end
				if (c_wout && wout_tot_q != '1) begin
					wout_tot_q <= wout_tot_q + 1'b1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.hit             = hit_q;
	assign rsp.memory_fetch    = fetch_q;
	assign rsp.memory_writeout = wout_q;
	assign rsp.fetch_total     = fetch_tot_q;
	assign rsp.writeout_total  = wout_tot_q;

endmodule

// ----- rtl/set_assoc_cache_tag_model.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model
// Tag-only set-associative cache with LRU, FIFO, LIFO, MRU and LFU replacement.
//
//   Channel   Dir  Handshake         Payload
//   req       in   valid/ready       opcode, set_index, tag
//   rsp       out  valid/ready       hit, memory_fetch, memory_writeout, totals
//   APB       in   psel/penable      policy, write_back_mode, ways_in_use
//
// In the back end, each access first reads the set row from the row memory,
// then updates the row and registers the result.
// After reset a clearing pass empties every set; no request is taken
// meanwhile. A two-entry queue lets requests arrive while the back end
// works or while a result waits to be taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_model (
	input  logic                        clk,
	input  logic                        arst_n,
	sacm_req_if.sink                    req,
	sacm_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sacm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [2:0]                  policy_q;
	logic                        wb_q;
	logic [sacm_pkg::FILL_W-1:0] ways_q;
	logic                        push, pop, q_full, q_empty, clearing;
	sacm_pkg::job_t              job_in, job_out;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 3'(sacm_pkg::POL_LRU);
			wb_q     <= 1'b1;
			ways_q   <= sacm_pkg::FILL_W'(sacm_pkg::MAX_WAYS);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				sacm_pkg::REG_POLICY: policy_q <= pwdata[2:0];
				sacm_pkg::REG_WB:     wb_q     <= pwdata[0];
				sacm_pkg::REG_WAYS:   ways_q   <= pwdata[sacm_pkg::FILL_W-1:0];
				default: begin
					wb_q <= wb_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			sacm_pkg::REG_POLICY: prdata = {29'd0, policy_q};
			sacm_pkg::REG_WB:     prdata = {31'd0, wb_q};
			sacm_pkg::REG_WAYS:   prdata = {28'd0, ways_q};
			default:              prdata = '0;
		endcase
	end

	sacm_front u_front (
		.req             (req),
		.policy          (policy_q),
		.write_back_mode (wb_q),
		.ways_in_use     (ways_q),
		.clearing        (clearing),
		.q_full          (q_full),
		.push            (push),
		.job             (job_in)
	);

	sacm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.pop    (pop),
		.dout   (job_out),
		.full   (q_full),
		.empty  (q_empty)
	);

	sacm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_job    (job_out),
		.q_empty  (q_empty),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);

endmodule

// ----- tb/set_assoc_cache_tag_model_tb.sv -----
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model_tb
// Drives read and write accesses through the request channel under every
// replacement policy and write mode, predicts each result from a behavioral
// copy of the tag store, and compares every transaction on the result channel.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_model_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		bit                       hit;
		bit                       fetch;
		bit                       wout;
		bit [sacm_pkg::TOT_W-1:0] fetch_total;
		bit [sacm_pkg::TOT_W-1:0] wout_total;
	} access_result_t;

	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [sacm_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;

	sacm_req_if req ();
	sacm_rsp_if rsp ();

	set_assoc_cache_tag_model uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the tag store and configuration.
	bit [sacm_pkg::TAG_W-1:0] sh_tag [sacm_pkg::NUM_SETS][sacm_pkg::MAX_WAYS];
	bit                       sh_dirty [sacm_pkg::NUM_SETS][sacm_pkg::MAX_WAYS];
	bit [sacm_pkg::CNT_W-1:0] sh_cnt [sacm_pkg::NUM_SETS][sacm_pkg::MAX_WAYS];
	int                       sh_fill [sacm_pkg::NUM_SETS];
	bit [sacm_pkg::TOT_W-1:0] fetch_count, wout_count;
	bit [2:0]       cfg_policy;
	bit             cfg_wb;
	bit [3:0]       cfg_ways;

	access_result_t pending_results[$];
	int  err_count;
	int  cycle_count;
	int  hold_request;
	bit [sacm_pkg::TAG_W-1:0] tag_pool[12];
	bit [sacm_pkg::SET_W-1:0] set_pool[4];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void row_put(int s, int p, bit [sacm_pkg::TAG_W-1:0] t, bit d,
			bit [sacm_pkg::CNT_W-1:0] c);
		sh_tag[s][p] = t;
		sh_dirty[s][p] = d;
		sh_cnt[s][p] = c;
	endfunction

	function automatic void row_remove(int s, int p, int n);
		for (int i = p; i + 1 < n; i++) row_put(s, i, sh_tag[s][i+1], sh_dirty[s][i+1], sh_cnt[s][i+1]);
	endfunction

	function automatic void row_insert_front(int s, int n, bit [sacm_pkg::TAG_W-1:0] t, bit d,
			bit [sacm_pkg::CNT_W-1:0] c);
		for (int i = n; i > 0; i--) row_put(s, i, sh_tag[s][i-1], sh_dirty[s][i-1], sh_cnt[s][i-1]);
		row_put(s, 0, t, d, c);
	endfunction

	function automatic access_result_t predict_access(bit wr, bit [sacm_pkg::SET_W-1:0] si,
			bit [sacm_pkg::TAG_W-1:0] t);
		access_result_t r;
		int s, n, ways, idx, v;
		bit front, lfu;
		bit [sacm_pkg::CNT_W-1:0] c;
		bit d;
		s = si;
		n = sh_fill[s];
		ways = cfg_ways;
		r = '{default: 0};
		if (ways == 0) ways = 1;
		if (ways > sacm_pkg::MAX_WAYS) ways = sacm_pkg::MAX_WAYS;
		front = (cfg_policy == sacm_pkg::POL_LRU) || (cfg_policy == sacm_pkg::POL_MRU);
		lfu = (cfg_policy == sacm_pkg::POL_LFU);
		idx = -1;
		for (int i = 0; i < n; i++) begin
			if (idx < 0 && sh_tag[s][i] == t) idx = i;
		end
		if (idx >= 0) begin
			r.hit = 1;
			if (wr == sacm_pkg::OP_WRITE) begin
				if (cfg_wb) sh_dirty[s][idx] = 1;
				else r.wout = 1;
			end
			if (front) begin
				c = sh_cnt[s][idx];
				d = sh_dirty[s][idx];
				row_remove(s, idx, n);
				row_insert_front(s, n - 1, t, d, c);
			end else if (lfu && sh_cnt[s][idx] != '1) begin
				sh_cnt[s][idx] = sacm_pkg::CNT_W'(sh_cnt[s][idx] + 1'b1);
			end
		end else begin
			r.fetch = 1;
			if (wr == sacm_pkg::OP_WRITE && !cfg_wb) r.wout = 1;
			if (n < ways) begin
				if (front) row_insert_front(s, n, t, wr, '0);
				else row_put(s, n, t, wr, '0);
				sh_fill[s] = n + 1;
			end else begin
				v = 0;
				if (cfg_policy == sacm_pkg::POL_LRU || cfg_policy == sacm_pkg::POL_LIFO) v = n - 1;
				else if (lfu) begin
					for (int i = 1; i < n; i++) if (sh_cnt[s][i] < sh_cnt[s][v]) v = i;
				end
				if (sh_dirty[s][v] && cfg_wb) r.wout = 1;
				if (lfu) row_put(s, v, t, wr, '0);
				else begin
					row_remove(s, v, n);
					if (front) row_insert_front(s, n - 1, t, wr, '0);
					else row_put(s, n - 1, t, wr, '0);
				end
			end
		end
		if (r.fetch && fetch_count != '1) fetch_count++;
		if (r.wout && wout_count != '1) wout_count++;
		r.fetch_total = fetch_count;
		r.wout_total = wout_count;
		return r;
	endfunction

	function automatic void queue_expected(access_result_t r);
		pending_results = {pending_results, r};
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 60) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one access; the valid stays high when the next one follows at once.
	task automatic send_access(bit wr, bit [sacm_pkg::SET_W-1:0] s,
			bit [sacm_pkg::TAG_W-1:0] t, int gap);
		req.valid <= 1'b1;
		req.opcode <= wr;
		req.set_index <= s;
		req.tag <= t;
		do @(posedge clk); while (!req.ready);
		queue_expected(predict_access(wr, s, t));
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] index, logic [31:0] value);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (index == sacm_pkg::REG_POLICY) cfg_policy = value[2:0];
		else if (index == sacm_pkg::REG_WB) cfg_wb = value[0];
		else if (index == sacm_pkg::REG_WAYS) cfg_ways = value[3:0];
	endtask

	task automatic set_config(bit [2:0] pol, bit wb, bit [3:0] ways);
		reg_write(sacm_pkg::REG_POLICY, {29'd0, pol});
		reg_write(sacm_pkg::REG_WB, {31'd0, wb});
		reg_write(sacm_pkg::REG_WAYS, {28'd0, ways});
	endtask

	task automatic send_random_access(int gap);
		bit [sacm_pkg::SET_W-1:0] s;
		bit [sacm_pkg::TAG_W-1:0] t;
		s = ($urandom_range(0, 9) == 0) ? sacm_pkg::SET_W'($urandom) :
			set_pool[$urandom_range(0, 3)];
		t = ($urandom_range(0, 9) == 0) ? sacm_pkg::TAG_W'({$urandom, $urandom}) :
			tag_pool[$urandom_range(0, cfg_ways > 9 ? 11 : cfg_ways + 2)];
		send_access(1'($urandom_range(0, 1)), s, t, gap);
	endtask

	task automatic test_directed();
		set_config(sacm_pkg::POL_LRU, 1'b1, 4'd2);
		send_access(sacm_pkg::OP_WRITE, 10'd0, '0, 0);
		send_access(sacm_pkg::OP_READ, 10'd0, '1, 1);
		send_access(sacm_pkg::OP_READ, 10'd0, '0, 0);
		send_access(sacm_pkg::OP_READ, 10'd0, 58'h155, 0);
		send_access(sacm_pkg::OP_WRITE, 10'd1023, '1, 2);
		send_access(sacm_pkg::OP_WRITE, 10'd1023, '1, 0);
		send_access(sacm_pkg::OP_READ, 10'd1023, 58'h2AA, 0);
		send_access(sacm_pkg::OP_READ, 10'd1023, 58'h3, 0);
		// Write-through with out-of-range associativity (zero acts as one).
		set_config(sacm_pkg::POL_LFU, 1'b0, 4'd0);
		send_access(sacm_pkg::OP_WRITE, 10'd5, 58'h1, 0);
		send_access(sacm_pkg::OP_WRITE, 10'd5, 58'h1, 0);
		send_access(sacm_pkg::OP_WRITE, 10'd5, 58'h2, 0);
		// Associativity above the maximum, then shrinking a full set.
		set_config(sacm_pkg::POL_LFU, 1'b1, 4'd15);
		for (int i = 0; i < 9; i++) send_access(sacm_pkg::OP_READ, 10'd7, 58'(i), 0);
		send_access(sacm_pkg::OP_READ, 10'd7, 58'd3, 0);
		reg_write(sacm_pkg::REG_WAYS, 32'd2);
		send_access(sacm_pkg::OP_WRITE, 10'd7, 58'h40, 0);
		send_access(sacm_pkg::OP_READ, 10'd7, 58'h41, 0);
	endtask

	task automatic test_policy_sweep();
		for (int p = 0; p < 8; p++) begin
			set_config(p[2:0], 1'($urandom_range(0, 1)),
				(p == 0) ? 4'd1 : (p == 1) ? 4'd8 : 4'($urandom_range(0, 15)));
			repeat (50) send_random_access(pick_gap());
		end
		set_config(sacm_pkg::POL_MRU, 1'b1, 4'd3);
		repeat (20) send_random_access(0);
	endtask

	// The receiver holds off long enough for the input queue to back up.
	task automatic test_backpressure();
		set_config(sacm_pkg::POL_LRU, 1'b1, 4'd4);
		hold_request = 300;
		repeat (20) send_random_access(0);
		drain_results();
		repeat (10) send_random_access(pick_gap());
	endtask

	always @(posedge clk) begin
		if (!arst_n) cycle_count <= 0;
		else cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	int stall_left;
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
		end
		if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		access_result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no access outstanding");
				err_count++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.hit !== e.hit) begin
					$error("hit: expected %0d, got %0d", e.hit, rsp.hit);
					err_count++;
				end
				if (rsp.memory_fetch !== e.fetch) begin
					$error("memory_fetch: expected %0d, got %0d", e.fetch, rsp.memory_fetch);
					err_count++;
				end
				if (rsp.memory_writeout !== e.wout) begin
					$error("memory_writeout: expected %0d, got %0d", e.wout,
						rsp.memory_writeout);
					err_count++;
				end
				if (rsp.fetch_total !== e.fetch_total) begin
					$error("fetch_total: expected %0d, got %0d", e.fetch_total,
						rsp.fetch_total);
					err_count++;
				end
				if (rsp.writeout_total !== e.wout_total) begin
					$error("writeout_total: expected %0d, got %0d", e.wout_total,
						rsp.writeout_total);
					err_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.opcode = sacm_pkg::OP_READ;
		req.set_index = '0;
		req.tag = '0;
		rsp.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		err_count = 0;
		hold_request = 0;
		stall_left = 0;
		cfg_policy = sacm_pkg::POL_LRU;
		cfg_wb = 1'b1;
		cfg_ways = 4'd8;
		fetch_count = '0;
		wout_count = '0;
		foreach (sh_fill[i]) sh_fill[i] = 0;
		foreach (tag_pool[i]) tag_pool[i] = sacm_pkg::TAG_W'({$urandom, $urandom});
		set_pool = '{10'd0, 10'd1023, 10'($urandom), 10'($urandom)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_policy_sweep();
		test_backpressure();
		drain_results();
		repeat (20) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
